// ===== hw/rtl/rotenc_pkg.sv =====
// rotenc_pkg: shared types and constants for the rotary encoder front end
// no dependencies; imported by rotenc_regs, rotenc_core and the top level
package rotenc_pkg;

    localparam int TICK_W = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register word index, taken from paddr[2]
    localparam logic REG_CONTACT = 1'b0;
    localparam logic REG_BUTTON  = 1'b1;

    localparam logic [TICK_W-1:0] CONTACT_TICKS_RST = 16'd10;
    localparam logic [TICK_W-1:0] BUTTON_TICKS_RST  = 16'd200;

    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_PIN_A     = 3'd1,
        FUNC_BUTTON    = 3'd2,
        FUNC_READ_MOVE = 3'd3,
        FUNC_READ_BTN  = 3'd4
    } func_t;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_ACW  = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0] contact_ticks;
        logic [TICK_W-1:0] button_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic       pin_a_level;
        logic       pin_b_level;
        logic       button_level;
    } req_t;

    typedef struct packed {
        logic [1:0] movement;
        logic       clicked;
    } res_t;

endpackage

// ===== hw/rtl/rotenc_regs.sv =====
// rotenc_regs: apb-style configuration registers (debounce tick settings)
// depends on rotenc_pkg
module rotenc_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rotenc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rotenc_pkg::DATA_W-1:0]   pwdata,
    output logic [rotenc_pkg::DATA_W-1:0]   prdata,
    output logic                            pready,
    output rotenc_pkg::cfg_t                cfg
);
    import rotenc_pkg::*;

    logic [TICK_W-1:0] contact_reg;
    logic [TICK_W-1:0] button_reg;
    logic              wr_en;
    logic              word_sel;

    // byte address bits below the word are ignored
    assign word_sel = paddr[2];
    assign wr_en    = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact_reg <= CONTACT_TICKS_RST;
            button_reg  <= BUTTON_TICKS_RST;
        end else if (wr_en) begin
            unique case (word_sel)
                REG_CONTACT: contact_reg <= pwdata[TICK_W-1:0];
                REG_BUTTON:  button_reg  <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (word_sel)
            REG_CONTACT: prdata[TICK_W-1:0] = contact_reg;
            REG_BUTTON:  prdata[TICK_W-1:0] = button_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.contact_ticks = contact_reg;
    assign cfg.button_ticks  = button_reg;

endmodule

// ===== hw/rtl/rotenc_core.sv =====
// rotenc_core: debounce counters, direction latch and click flag
// depends on rotenc_pkg; result is combinational from the request being retired
module rotenc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  rotenc_pkg::req_t  req,
    input  rotenc_pkg::cfg_t  cfg,
    output rotenc_pkg::res_t  res
);
    import rotenc_pkg::*;

    logic [TICK_W-1:0] rise_counter_reg, rise_counter_next;
    logic [TICK_W-1:0] press_counter_reg, press_counter_next;
    logic              move_pending_reg, move_pending_next;
    logic [1:0]        latched_dir_reg, latched_dir_next;
    logic [1:0]        prev_dir_reg, prev_dir_next;
    logic              click_pending_reg, click_pending_next;

    always_comb begin
        rise_counter_next  = rise_counter_reg;
        press_counter_next = press_counter_reg;
        move_pending_next  = move_pending_reg;
        latched_dir_next   = latched_dir_reg;
        prev_dir_next      = prev_dir_reg;
        click_pending_next = click_pending_reg;
        res                = '0;

        if (fire) begin
            unique case (func_t'(req.func))
                FUNC_TICK: begin
                    if (rise_counter_reg != '0) begin
                        rise_counter_next = rise_counter_reg - 1'b1;
                        // expiry while a step is pending leaves the latch alone
                        if (rise_counter_reg == TICK_W'(1) && !move_pending_reg) begin
                            latched_dir_next  = req.pin_b_level ? DIR_CW : DIR_ACW;
                            move_pending_next = 1'b1;
                        end
                    end
                    if (press_counter_reg != '0) begin
                        press_counter_next = press_counter_reg - 1'b1;
                        if (press_counter_reg == TICK_W'(1)) begin
                            click_pending_next = 1'b1;
                        end
                    end
                end
                FUNC_PIN_A: begin
                    if (req.pin_a_level) begin
                        rise_counter_next = cfg.contact_ticks;
                    end
                end
                FUNC_BUTTON: begin
                    if (req.button_level) begin
                        press_counter_next = cfg.button_ticks;
                    end
                end
                FUNC_READ_MOVE: begin
                    if (move_pending_reg) begin
                        move_pending_next = 1'b0;
                        // two agreeing detents confirm a step
                        if (latched_dir_reg == prev_dir_reg) begin
                            res.movement = latched_dir_reg;
                        end
                        prev_dir_next = latched_dir_reg;
                    end
                end
                FUNC_READ_BTN: begin
                    res.clicked        = click_pending_reg;
                    click_pending_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_counter_reg  <= '0;
            press_counter_reg <= '0;
            move_pending_reg  <= 1'b0;
            latched_dir_reg   <= DIR_NONE;
            prev_dir_reg      <= DIR_NONE;
            click_pending_reg <= 1'b0;
        end else begin
            rise_counter_reg  <= rise_counter_next;
            press_counter_reg <= press_counter_next;
            move_pending_reg  <= move_pending_next;
            latched_dir_reg   <= latched_dir_next;
            prev_dir_reg      <= prev_dir_next;
            click_pending_reg <= click_pending_next;
        end
    end

    a_pending_has_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        move_pending_reg |-> (latched_dir_reg == DIR_CW || latched_dir_reg == DIR_ACW))
        else $error("step pending without a latched direction");

    a_dir_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_dir_reg != 2'd3 && prev_dir_reg != 2'd3)
        else $error("direction register holds an unused code");

    a_move_confirmed: assert property (@(posedge aclk) disable iff (!aresetn)
        res.movement != DIR_NONE |-> move_pending_reg && latched_dir_reg == prev_dir_reg)
        else $error("movement reported without a confirmed step");

    a_click_on_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(click_pending_reg) |-> $past(press_counter_reg) == TICK_W'(1))
        else $error("click flagged without button counter expiry");

endmodule

// ===== hw/rtl/rotary_encoder_debounce_decoder.sv =====
// rotary_encoder_debounce_decoder: top level of the rotary encoder front end
// depends on rotenc_pkg, rotenc_regs and rotenc_core
//
// usage:
//   requests enter on the s_ channel (valid/ready), one event each: a tick,
//   a pin A change, a button change, a movement read or a button read.
//   every request yields exactly one result on the m_ channel: m_movement on
//   a movement read, m_clicked on a button read, zeros otherwise.
//   the debounce lengths sit in two apb registers: contact ticks at byte
//   address 0, button ticks at byte address 4; write them only while idle.
// path: an accepted request passes through the input register, then the result
//   register, which drives the m_ channel.
// throughput: one request per cycle while m_ready is high; the counters and flags
//   update in the same cycle in which a request moves from the input register to the result
//   register.
// stalls: while m_ready is low the result register holds; one more request
//   may wait in the input register, after that s_ready drops.
// reset: aresetn (synchronous, active low) empties both registers, clears the
//   counters and flags, and restores 10 contact ticks and 200 button ticks.
module rotary_encoder_debounce_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_func,
    input  logic                            s_pin_a_level,
    input  logic                            s_pin_b_level,
    input  logic                            s_button_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_movement,
    output logic                            m_clicked,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rotenc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rotenc_pkg::DATA_W-1:0]   pwdata,
    output logic [rotenc_pkg::DATA_W-1:0]   prdata,
    output logic                            pready
);
    import rotenc_pkg::*;

    cfg_t cfg;
    req_t in_req_reg;
    logic in_valid_reg;
    res_t core_res;
    res_t out_res_reg;
    logic out_valid_reg;
    logic advance;

    rotenc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the request retires into the result register when that register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rotenc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .req     (in_req_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.func         <= s_func;
            in_req_reg.pin_a_level  <= s_pin_a_level;
            in_req_reg.pin_b_level  <= s_pin_b_level;
            in_req_reg.button_level <= s_button_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_movement = out_res_reg.movement;
    assign m_clicked  = out_res_reg.clicked;

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for rotary_encoder_debounce_decoder
// runs encoder and button event streams and compares each result against a local predictor
// depends on rotenc_pkg and the rotary_encoder_debounce_decoder top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rotenc_pkg::*;

    // func codes the block ignores
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 250;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_func = '0;
    logic s_pin_a_level = 1'b0;
    logic s_pin_b_level = 1'b0;
    logic s_button_level = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_movement;
    logic m_clicked;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    rotary_encoder_debounce_decoder dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_pin_a_level(s_pin_a_level),
        .s_pin_b_level(s_pin_b_level),
        .s_button_level(s_button_level),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_movement(m_movement),
        .m_clicked(m_clicked),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4ns aclk = ~aclk;

    // predicted encoder state
    logic [TICK_W-1:0] cfg_contact = CONTACT_TICKS_RST;
    logic [TICK_W-1:0] cfg_button = BUTTON_TICKS_RST;
    logic [TICK_W-1:0] rise_cnt = '0;
    logic [TICK_W-1:0] press_cnt = '0;
    logic move_pend = 1'b0;
    logic [1:0] dir_latched = DIR_NONE;
    logic [1:0] dir_prev = DIR_NONE;
    logic click_pend = 1'b0;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int queued = 0;
    int errors = 0;
    logic dir_bit = 1'b1;

    function automatic res_t decode_event(req_t r);
        res_t res;
        res = '0;
        case (r.func)
            FUNC_TICK: begin
                if (rise_cnt != 0) begin
                    rise_cnt = rise_cnt - 1'b1;
                    if (rise_cnt == 0 && !move_pend) begin
                        dir_latched = r.pin_b_level ? DIR_CW : DIR_ACW;
                        move_pend = 1'b1;
                    end
                end
                if (press_cnt != 0) begin
                    press_cnt = press_cnt - 1'b1;
                    if (press_cnt == 0)
                        click_pend = 1'b1;
                end
            end
            FUNC_PIN_A: begin
                if (r.pin_a_level)
                    rise_cnt = cfg_contact;
            end
            FUNC_BUTTON: begin
                if (r.button_level)
                    press_cnt = cfg_button;
            end
            FUNC_READ_MOVE: begin
                if (move_pend) begin
                    move_pend = 1'b0;
                    // two agreeing detents in a row confirm a step
                    if (dir_latched == dir_prev)
                        res.movement = dir_latched;
                    dir_prev = dir_latched;
                end
            end
            FUNC_READ_BTN: begin
                res.clicked = click_pend;
                click_pend = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic queue_req(input logic [2:0] f, input logic a, input logic b,
                             input logic btn);
        req_t r;
        r.func = f;
        r.pin_a_level = a;
        r.pin_b_level = b;
        r.button_level = btn;
        pending_reqs.push_back(r);
        queued++;
    endtask

    // mostly detent and button-press sequences, the rest random noise
    task automatic queue_random(input int n);
        int start;
        int pick;
        int ticks;
        logic b;
        start = queued;
        while (queued - start < n) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                if ($urandom_range(0, 3) == 0) begin
                    // contact bounce before the real rise
                    queue_req(FUNC_PIN_A, 1'b1, rbit(), rbit());
                    queue_req(FUNC_PIN_A, 1'b0, rbit(), rbit());
                end
                queue_req(FUNC_PIN_A, 1'b1, rbit(), rbit());
                b = ($urandom_range(0, 3) != 0) ? dir_bit : rbit();
                dir_bit = b;
                ticks = (cfg_contact > 30) ? 30 : int'(cfg_contact);
                ticks = ticks + $urandom_range(0, 2);
                if (ticks > 0 && $urandom_range(0, 3) == 0)
                    ticks--;
                repeat (ticks) queue_req(FUNC_TICK, rbit(), b, rbit());
                if ($urandom_range(0, 4) != 0)
                    queue_req(FUNC_READ_MOVE, rbit(), rbit(), rbit());
            end else if (pick < 8) begin
                queue_req(FUNC_BUTTON, rbit(), rbit(), 1'b1);
                if (rbit())
                    queue_req(FUNC_BUTTON, rbit(), rbit(), 1'b0);
                ticks = (cfg_button > 30) ? 30 : int'(cfg_button);
                ticks = ticks + $urandom_range(0, 2);
                if (ticks > 0 && $urandom_range(0, 3) == 0)
                    ticks--;
                repeat (ticks) queue_req(FUNC_TICK, rbit(), rbit(), rbit());
                queue_req(FUNC_READ_BTN, rbit(), rbit(), rbit());
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_req(3'($urandom_range(0, 7)), rbit(), rbit(), rbit());
            end
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [TICK_W-1:0] val);
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] word;
        addr = {idx, 2'b00};
        word = {{(DATA_W-TICK_W){1'b0}}, val};
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_CONTACT)
            cfg_contact = val;
        else
            cfg_button = val;
        // read it back
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== word) begin
            $display("%0t: register %0d readback mismatch, expected %0h actual %0h",
                     $time, idx, word, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [TICK_W-1:0] contact,
                             input logic [TICK_W-1:0] button, input int n);
        cfg_write(REG_CONTACT, contact);
        cfg_write(REG_BUTTON, button);
        queue_random(n);
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first
        queue_random(150);
        wait_idle();

        cfg_write(REG_CONTACT, 16'd3);
        cfg_write(REG_BUTTON, 16'd4);
        queue_req(FUNC_READ_MOVE, 1'b1, 1'b1, 1'b1);
        queue_req(FUNC_READ_BTN, 1'b1, 1'b1, 1'b1);
        queue_req(FUNC_SPARE_5, 1'b1, 1'b1, 1'b1);
        queue_req(FUNC_SPARE_6, 1'b1, 1'b1, 1'b1);
        queue_req(FUNC_SPARE_7, 1'b1, 1'b1, 1'b1);
        queue_req(FUNC_PIN_A, 1'b1, 1'b0, 1'b0);
        repeat (3) queue_req(FUNC_TICK, 1'b0, 1'b1, 1'b0);
        queue_req(FUNC_PIN_A, 1'b0, 1'b1, 1'b1);
        // expiry with a step already pending must not overwrite it
        queue_req(FUNC_PIN_A, 1'b1, 1'b1, 1'b0);
        repeat (3) queue_req(FUNC_TICK, 1'b1, 1'b0, 1'b1);
        queue_req(FUNC_READ_MOVE, 1'b0, 1'b0, 1'b0);
        queue_req(FUNC_PIN_A, 1'b1, 1'b0, 1'b1);
        repeat (3) queue_req(FUNC_TICK, 1'b0, 1'b1, 1'b1);
        queue_req(FUNC_READ_MOVE, 1'b0, 1'b0, 1'b0);
        queue_req(FUNC_BUTTON, 1'b0, 1'b0, 1'b1);
        queue_req(FUNC_BUTTON, 1'b1, 1'b1, 1'b0);
        repeat (4) queue_req(FUNC_TICK, 1'b1, 1'b0, 1'b0);
        queue_req(FUNC_READ_BTN, 1'b0, 1'b0, 1'b0);
        wait_idle();

        run_phase(16'd0, 16'd0, 150);
        run_phase(16'd1, 16'd1, 200);
        run_phase(16'hFFFF, 16'hFFFF, 100);
        run_phase(16'd2, 16'd9, 200);
        run_phase(16'd6, 16'hFFFF, 100);
        run_phase(16'd0, 16'd3, 150);

        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // sender: bursts of requests with random gaps
    req_t cur_req;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(decode_event(cur_req));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_func <= cur_req.func;
                    s_pin_a_level <= cur_req.pin_a_level;
                    s_pin_b_level <= cur_req.pin_b_level;
                    s_button_level <= cur_req.button_level;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall pattern plus a long hold-off now and then
    logic [15:0] stall_pat = '1;
    int pat_age = 0;
    int hold_left = 0;
    int results_seen = 0;
    res_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual movement %0d clicked %0d",
                             $time, m_movement, m_clicked);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_movement !== want.movement) begin
                        $display("%0t: movement mismatch, expected %0d actual %0d",
                                 $time, want.movement, m_movement);
                        errors++;
                    end
                    if (m_clicked !== want.clicked) begin
                        $display("%0t: clicked mismatch, expected %0d actual %0d",
                                 $time, want.clicked, m_clicked);
                        errors++;
                    end
                end
                // back up the block while the sender keeps offering
                if (results_seen % 400 == 300)
                    hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pat_age == 0) begin
                    pat_age = 48;
                    stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                end else begin
                    pat_age--;
                end
                m_ready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    int cycles = 0;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
